/* design/jsue_pkg.sv */
// Shared types, codes and character helpers for the JSON string escaper.
`default_nettype none
package jsue_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;

  localparam logic [15:0] REPL_CP = 16'hfffd;
  // Index of the last character of a six-character \uXXXX escape.
  localparam logic [2:0] UESC_LAST = 3'd5;

  // Controller states; each non-idle state emits one segment of the result.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_OPEN  = 7'b0000010,
    ST_REP1  = 7'b0000100,
    ST_COPY  = 7'b0001000,
    ST_FRESH = 7'b0010000,
    ST_REP2  = 7'b0100000,
    ST_CLOSE = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    FK_NONE = 2'd0,
    FK_LIT  = 2'd1,
    FK_ESC  = 2'd2,
    FK_UESC = 2'd3
  } fresh_kind_t;

  // Result plan of one item: segment sizes in emission order.
  typedef struct packed {
    logic       open_q;
    logic [2:0] rep1;
    logic [2:0] copy_len;
    logic [2:0] fresh_len;
    logic [2:0] rep2;
    logic       close_q;
  } plan_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    state_t     seg;
    logic [2:0] idx;
    logic       last;
    logic       done;
  } cmd_t;

  typedef struct packed {
    plan_t plan_in;
    plan_t plan_r;
    logic  out_free;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CH_0 + {4'd0, n};
    end else begin
      r = CH_A + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [7:0] uesc_char(input logic [2:0] idx, input logic [15:0] v);
    logic [7:0] r;
    case (idx)
      3'd0:    r = CH_BSL;
      3'd1:    r = CH_U;
      3'd2:    r = hex_char(v[15:12]);
      3'd3:    r = hex_char(v[11:8]);
      3'd4:    r = hex_char(v[7:4]);
      default: r = hex_char(v[3:0]);
    endcase
    return r;
  endfunction

  // First non-empty segment after the given state, or idle when none is left.
  function automatic state_t next_seg(input state_t s, input plan_t p);
    logic [6:0] ne;
    logic [6:0] sv;
    logic [6:0] cand;
    logic [6:0] pick;
    state_t     r;
    ne   = {p.close_q, p.rep2 != 3'd0, p.fresh_len != 3'd0, p.copy_len != 3'd0,
            p.rep1 != 3'd0, p.open_q, 1'b0};
    sv   = s;
    cand = ne & ~(sv | (sv - 7'd1));
    pick = cand & (~cand + 7'd1);
    if (pick == 7'd0) begin
      r = ST_IDLE;
    end else begin
      r = state_t'(pick);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/jsue_ctrl.sv */
// Sequencer that walks the segments of an item's result plan, one byte per cycle while the output stage is free.
`default_nettype none
module jsue_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  jsue_pkg::status_t st,
  output jsue_pkg::cmd_t    cmd
);

  jsue_pkg::state_t state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] rep_r, rep_nxt;
  logic       seg_end;

  assign in_ready = (state_r == jsue_pkg::ST_IDLE);

  always_comb begin
    unique case (state_r)
      jsue_pkg::ST_REP1:  seg_end = (idx_r == jsue_pkg::UESC_LAST) &&
                                    (rep_r == st.plan_r.rep1 - 3'd1);
      jsue_pkg::ST_REP2:  seg_end = (idx_r == jsue_pkg::UESC_LAST) &&
                                    (rep_r == st.plan_r.rep2 - 3'd1);
      jsue_pkg::ST_COPY:  seg_end = (idx_r == st.plan_r.copy_len - 3'd1);
      jsue_pkg::ST_FRESH: seg_end = (idx_r == st.plan_r.fresh_len - 3'd1);
      default:            seg_end = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rep_nxt   = rep_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.seg   = state_r;
    cmd.idx   = idx_r;
    cmd.last  = 1'b0;
    cmd.done  = (state_r == jsue_pkg::ST_CLOSE);
    if (state_r == jsue_pkg::ST_IDLE) begin
      if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = jsue_pkg::next_seg(jsue_pkg::ST_IDLE, st.plan_in);
        idx_nxt   = 3'd0;
        rep_nxt   = 3'd0;
      end
    end else if (st.out_free) begin
      cmd.emit = 1'b1;
      if (seg_end) begin
        state_nxt = jsue_pkg::next_seg(state_r, st.plan_r);
        cmd.last  = (state_nxt == jsue_pkg::ST_IDLE);
        idx_nxt   = 3'd0;
        rep_nxt   = 3'd0;
      end else if ((state_r == jsue_pkg::ST_REP1 || state_r == jsue_pkg::ST_REP2) &&
                   idx_r == jsue_pkg::UESC_LAST) begin
        // wrap to the next replacement escape
        idx_nxt = 3'd0;
        rep_nxt = rep_r + 3'd1;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsue_pkg::ST_IDLE;
      idx_r   <= 3'd0;
      rep_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rep_r   <= rep_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/jsue_dp.sv */
// Datapath: UTF-8 hold state, result planning, byte selection and output register.
`default_nettype none
module jsue_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  wire  [7:0]         in_byte,
  input  wire                has_byte,
  input  wire                string_start,
  input  wire                string_end,
  input  jsue_pkg::cmd_t     cmd,
  output jsue_pkg::status_t  st,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               string_done
);

  logic [7:0] held_r [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] exp_r, exp_nxt;

  jsue_pkg::plan_t       plan_r, plan_nxt;
  logic [7:0]            cb_r [4];
  logic [7:0]            cb_nxt [4];
  jsue_pkg::fresh_kind_t fkind_r, fkind_nxt;
  logic [7:0]            fch_r, fch_nxt;
  logic [15:0]           fval_r, fval_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;

  logic [1:0] eff_cnt;
  logic [2:0] eff_exp;
  logic       do_fresh;
  logic       held_we;
  logic [1:0] held_wa;
  logic [7:0] second;
  logic       seq_ok;
  logic [7:0] sel_byte;

  assign eff_cnt = string_start ? 2'd0 : cnt_r;
  assign eff_exp = string_start ? 3'd0 : exp_r;
  assign second  = (eff_cnt >= 2'd2) ? held_r[1] : in_byte;

  always_comb begin
    seq_ok = 1'b1;
    if (eff_exp == 3'd2 && held_r[0] < 8'hc2) begin
      seq_ok = 1'b0;
    end
    if (eff_exp == 3'd3 && held_r[0] == 8'he0 && second < 8'ha0) begin
      seq_ok = 1'b0;
    end
    if (eff_exp == 3'd4) begin
      if (held_r[0] > 8'hf4) seq_ok = 1'b0;
      if (held_r[0] == 8'hf0 && second < 8'h90) seq_ok = 1'b0;
      if (held_r[0] == 8'hf4 && second > 8'h8f) seq_ok = 1'b0;
    end
  end

  // Held bytes in order, followed by the incoming byte.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cb_nxt[i] = (2'(i) < eff_cnt) ? held_r[i] : in_byte;
    end
    cb_nxt[3] = in_byte;
  end

  always_comb begin
    plan_nxt        = '0;
    plan_nxt.open_q = string_start;
    do_fresh        = 1'b0;
    held_we         = 1'b0;
    held_wa         = eff_cnt;
    cnt_nxt         = eff_cnt;
    exp_nxt         = eff_exp;
    fkind_nxt       = jsue_pkg::FK_NONE;
    fch_nxt         = in_byte;
    fval_nxt        = jsue_pkg::REPL_CP;
    if (has_byte) begin
      if (eff_cnt == 2'd0) begin
        do_fresh = 1'b1;
      end else if (in_byte[7:6] != 2'b10) begin
        // broken sequence: replace held bytes, then take the byte afresh
        plan_nxt.rep1 = {1'b0, eff_cnt};
        do_fresh      = 1'b1;
      end else if ({1'b0, eff_cnt} + 3'd1 < eff_exp) begin
        held_we = 1'b1;
        cnt_nxt = eff_cnt + 2'd1;
      end else begin
        if (seq_ok) begin
          plan_nxt.copy_len = {1'b0, eff_cnt} + 3'd1;
        end else begin
          plan_nxt.rep1 = {1'b0, eff_cnt} + 3'd1;
        end
        cnt_nxt = 2'd0;
        exp_nxt = 3'd0;
      end
    end
    if (do_fresh) begin
      cnt_nxt = 2'd0;
      exp_nxt = 3'd0;
      if (in_byte == jsue_pkg::CH_QUOTE || in_byte == jsue_pkg::CH_BSL) begin
        fkind_nxt = jsue_pkg::FK_ESC;
      end else if (in_byte == jsue_pkg::CH_LF) begin
        fkind_nxt = jsue_pkg::FK_ESC;
        fch_nxt   = jsue_pkg::CH_N;
      end else if (in_byte == jsue_pkg::CH_CR) begin
        fkind_nxt = jsue_pkg::FK_ESC;
        fch_nxt   = jsue_pkg::CH_R;
      end else if (in_byte == jsue_pkg::CH_TAB) begin
        fkind_nxt = jsue_pkg::FK_ESC;
        fch_nxt   = jsue_pkg::CH_T;
      end else if (in_byte < 8'h20) begin
        fkind_nxt = jsue_pkg::FK_UESC;
        fval_nxt  = {8'h00, in_byte};
      end else if (in_byte < 8'h80) begin
        fkind_nxt = jsue_pkg::FK_LIT;
      end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                   in_byte[7:3] == 5'b11110) begin
        // lead byte: start holding
        held_we = 1'b1;
        held_wa = 2'd0;
        cnt_nxt = 2'd1;
        if (in_byte[7:5] == 3'b110) begin
          exp_nxt = 3'd2;
        end else if (in_byte[7:4] == 4'b1110) begin
          exp_nxt = 3'd3;
        end else begin
          exp_nxt = 3'd4;
        end
      end else begin
        fkind_nxt = jsue_pkg::FK_UESC;
      end
    end
    case (fkind_nxt)
      jsue_pkg::FK_LIT:  plan_nxt.fresh_len = 3'd1;
      jsue_pkg::FK_ESC:  plan_nxt.fresh_len = 3'd2;
      jsue_pkg::FK_UESC: plan_nxt.fresh_len = 3'd6;
      default:           plan_nxt.fresh_len = 3'd0;
    endcase
    if (string_end) begin
      plan_nxt.rep2    = {1'b0, cnt_nxt};
      plan_nxt.close_q = 1'b1;
      cnt_nxt          = 2'd0;
      exp_nxt          = 3'd0;
    end
  end

  always_comb begin
    unique case (cmd.seg)
      jsue_pkg::ST_OPEN, jsue_pkg::ST_CLOSE: sel_byte = jsue_pkg::CH_QUOTE;
      jsue_pkg::ST_REP1, jsue_pkg::ST_REP2:
        sel_byte = jsue_pkg::uesc_char(cmd.idx, jsue_pkg::REPL_CP);
      jsue_pkg::ST_COPY: sel_byte = cb_r[cmd.idx[1:0]];
      jsue_pkg::ST_FRESH: begin
        case (fkind_r)
          jsue_pkg::FK_LIT:  sel_byte = fch_r;
          jsue_pkg::FK_ESC:  sel_byte = (cmd.idx == 3'd0) ? jsue_pkg::CH_BSL : fch_r;
          jsue_pkg::FK_UESC: sel_byte = jsue_pkg::uesc_char(cmd.idx, fval_r);
          default:           sel_byte = 8'd0;
        endcase
      end
      default: sel_byte = 8'd0;
    endcase
  end

  assign st.plan_in  = plan_nxt;
  assign st.plan_r   = plan_r;
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      exp_r <= 3'd0;
    end else if (cmd.load) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      plan_r  <= plan_nxt;
      fkind_r <= fkind_nxt;
      fch_r   <= fch_nxt;
      fval_r  <= fval_nxt;
      for (int i = 0; i < 4; i++) begin
        cb_r[i] <= cb_nxt[i];
      end
      for (int i = 0; i < 3; i++) begin
        if (held_we && held_wa == 2'(i)) begin
          held_r[i] <= in_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= cmd.last;
      out_done_r <= cmd.done;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign run_last    = out_last_r;
  assign string_done = out_done_r;

endmodule
`default_nettype wire

/* design/json_string_utf8_escaper.sv */
// Top level of the JSON string escaper with UTF-8 validation.
// Each accepted item is one string byte (or an empty-string marker) plus start and end
// flags; the block plans the item's whole result at acceptance and then sends it one
// escaped byte per cycle through a registered output stage. Each item is accepted, then
// its result bytes go out through the controller's single byte-wide emission path; an
// item that causes no result emits nothing. A new item is taken as soon as the last
// result byte of the previous one has been loaded into the output register.
// Backpressure on the output stalls emission.
// There is no clearing pass after reset.
`default_nettype none
module json_string_utf8_escaper (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] in_byte
  input  wire  [1:0]  in_tuser,   // [0] has_byte, [1] string_start
  input  wire         in_tlast,   // string_end
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] string_done
  output logic        out_tlast   // run_last
);

  jsue_pkg::cmd_t    cmd;
  jsue_pkg::status_t st;

  jsue_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  jsue_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_byte      (in_tdata),
    .has_byte     (in_tuser[0]),
    .string_start (in_tuser[1]),
    .string_end   (in_tlast),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .run_last     (out_tlast),
    .string_done  (out_tuser)
  );

endmodule
`default_nettype wire
